// ===== hdl/yuv2argb_pkg.sv =====
`default_nettype none
package yuv2argb_pkg;

  localparam int BaseWidth  = 25;
  localparam int StepWidth  = 18;
  localparam int CodeWidth  = 8;
  localparam int IndexWidth = 4;
  localparam int TermWidth  = 12;
  localparam int SumWidth   = 28;
  localparam int ChanWidth  = 14;
  localparam int TermCount  = 4;

  typedef logic signed [BaseWidth-1:0] base_t;
  typedef logic        [StepWidth-1:0] step_t;
  typedef logic        [CodeWidth-1:0] code_t;
  typedef logic signed [TermWidth-1:0] term_t;

  // Term slots.
  localparam logic [1:0] TERM_RED_V   = 2'd0;
  localparam logic [1:0] TERM_GREEN_V = 2'd1;
  localparam logic [1:0] TERM_GREEN_U = 2'd2;
  localparam logic [1:0] TERM_BLUE_U  = 2'd3;

  // Configuration register indexes.
  localparam logic [IndexWidth-1:0] REG_RED_V_BASE   = 4'd0;
  localparam logic [IndexWidth-1:0] REG_RED_V_STEP   = 4'd1;
  localparam logic [IndexWidth-1:0] REG_GREEN_V_BASE = 4'd2;
  localparam logic [IndexWidth-1:0] REG_GREEN_V_STEP = 4'd3;
  localparam logic [IndexWidth-1:0] REG_GREEN_U_BASE = 4'd4;
  localparam logic [IndexWidth-1:0] REG_GREEN_U_STEP = 4'd5;
  localparam logic [IndexWidth-1:0] REG_BLUE_U_BASE  = 4'd6;
  localparam logic [IndexWidth-1:0] REG_BLUE_U_STEP  = 4'd7;

  localparam base_t RESET_RED_V_BASE   = -25'sd14487936;
  localparam step_t RESET_RED_V_STEP   = 18'd113443;
  localparam base_t RESET_GREEN_V_BASE = -25'sd5822464;
  localparam step_t RESET_GREEN_V_STEP = 18'd45744;
  localparam base_t RESET_GREEN_U_BASE = -25'sd2785792;
  localparam step_t RESET_GREEN_U_STEP = 18'd22020;
  localparam base_t RESET_BLUE_U_BASE  = -25'sd14496256;
  localparam step_t RESET_BLUE_U_STEP  = 18'd113508;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // floor((base + step * code) / 65536); the sum stays well inside 28 bits.
  function automatic term_t chroma_term(base_t base, step_t step, code_t code);
    logic        [StepWidth+CodeWidth-1:0] prod;
    logic signed [SumWidth-1:0]            sum;
    prod = step * code;
    sum  = SumWidth'(base) + $signed({2'b00, prod});
    return sum[SumWidth-1:16];
  endfunction

  function automatic logic [7:0] clamp8(logic signed [ChanWidth-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] make_pixel(code_t y, term_t tr,
                                             logic signed [TermWidth:0] tg, term_t tb);
    logic signed [ChanWidth-1:0] yy;
    logic signed [ChanWidth-1:0] r;
    logic signed [ChanWidth-1:0] g;
    logic signed [ChanWidth-1:0] b;
    yy = $signed({{(ChanWidth-CodeWidth){1'b0}}, y});
    r  = yy + ChanWidth'(tr);
    g  = yy - ChanWidth'(tg);
    b  = yy + ChanWidth'(tb);
    return {ALPHA_OPAQUE, clamp8(r), clamp8(g), clamp8(b)};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/yuv420_block_to_argb.sv =====
// done rises as the result register takes the item over from the input register.
// Throughput: one 2x2 block per clock cycle; busy is always low.
// The path between the input register and the result register holds one 18x8
// multiply and add per chroma term, then the channel sums and clamps.
// Synchronous reset clears the pipeline valid flags and restores the register defaults.
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none
module yuv420_block_to_argb (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output      logic                                 busy,
  input  wire logic [7:0]                           luma_top_left,
  input  wire logic [7:0]                           luma_top_right,
  input  wire logic [7:0]                           luma_bottom_left,
  input  wire logic [7:0]                           luma_bottom_right,
  input  wire logic [7:0]                           chroma_u,
  input  wire logic [7:0]                           chroma_v,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [yuv2argb_pkg::IndexWidth-1:0]  cfg_index,
  input  wire logic [yuv2argb_pkg::BaseWidth-1:0]   cfg_data,
  output      logic                                 done,
  output      logic [31:0]                          pixel_top_left,
  output      logic [31:0]                          pixel_top_right,
  output      logic [31:0]                          pixel_bottom_left,
  output      logic [31:0]                          pixel_bottom_right
);
  import yuv2argb_pkg::*;

  base_t base [TermCount];
  step_t step [TermCount];

  logic  in_valid;
  code_t y_tl;
  code_t y_tr;
  code_t y_bl;
  code_t y_br;
  code_t cu;
  code_t cv;

  term_t                 tr;
  term_t                 tgv;
  term_t                 tgu;
  term_t                 tb;
  logic signed [TermWidth:0] tg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base[TERM_RED_V]   <= RESET_RED_V_BASE;
      step[TERM_RED_V]   <= RESET_RED_V_STEP;
      base[TERM_GREEN_V] <= RESET_GREEN_V_BASE;
      step[TERM_GREEN_V] <= RESET_GREEN_V_STEP;
      base[TERM_GREEN_U] <= RESET_GREEN_U_BASE;
      step[TERM_GREEN_U] <= RESET_GREEN_U_STEP;
      base[TERM_BLUE_U]  <= RESET_BLUE_U_BASE;
      step[TERM_BLUE_U]  <= RESET_BLUE_U_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RED_V_BASE:   base[TERM_RED_V]   <= cfg_data;
        REG_RED_V_STEP:   step[TERM_RED_V]   <= cfg_data[StepWidth-1:0];
        REG_GREEN_V_BASE: base[TERM_GREEN_V] <= cfg_data;
        REG_GREEN_V_STEP: step[TERM_GREEN_V] <= cfg_data[StepWidth-1:0];
        REG_GREEN_U_BASE: base[TERM_GREEN_U] <= cfg_data;
        REG_GREEN_U_STEP: step[TERM_GREEN_U] <= cfg_data[StepWidth-1:0];
        REG_BLUE_U_BASE:  base[TERM_BLUE_U]  <= cfg_data;
        REG_BLUE_U_STEP:  step[TERM_BLUE_U]  <= cfg_data[StepWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      y_tl <= luma_top_left;
      y_tr <= luma_top_right;
      y_bl <= luma_bottom_left;
      y_br <= luma_bottom_right;
      cu   <= chroma_u;
      cv   <= chroma_v;
    end
  end

  always_comb begin
    tr  = chroma_term(base[TERM_RED_V],   step[TERM_RED_V],   cv);
    tgv = chroma_term(base[TERM_GREEN_V], step[TERM_GREEN_V], cv);
    tgu = chroma_term(base[TERM_GREEN_U], step[TERM_GREEN_U], cu);
    tb  = chroma_term(base[TERM_BLUE_U],  step[TERM_BLUE_U],  cu);
    tg  = (TermWidth+1)'(tgv) + (TermWidth+1)'(tgu);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pixel_top_left     <= make_pixel(y_tl, tr, tg, tb);
      pixel_top_right    <= make_pixel(y_tr, tr, tg, tb);
      pixel_bottom_left  <= make_pixel(y_bl, tr, tg, tb);
      pixel_bottom_right <= make_pixel(y_br, tr, tg, tb);
    end
  end

  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without an item in the input register");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("item in the input register produced no result");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    done |-> (pixel_top_left[31:24] == ALPHA_OPAQUE) && (pixel_top_right[31:24] == ALPHA_OPAQUE)
             && (pixel_bottom_left[31:24] == ALPHA_OPAQUE)
             && (pixel_bottom_right[31:24] == ALPHA_OPAQUE))
    else $error("alpha channel of a result is not opaque");

endmodule
`default_nettype wire

// ===== bench/yuv420_block_to_argb_tb.sv =====
`timescale 1ns / 1ps

module yuv420_block_to_argb_tb;
  import yuv2argb_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int DrainCycles = 4;
  localparam int RegCount = 2 * TermCount;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [IndexWidth-1:0] REG_SPARE_FIRST = REG_BLUE_U_STEP + 1'b1;
  localparam logic [IndexWidth-1:0] REG_SPARE_LAST  = '1;

  localparam logic [BaseWidth-1:0] BaseMost     = 25'h0FFFFFF;
  localparam logic [BaseWidth-1:0] BaseLeast    = 25'h1000000;
  localparam logic [BaseWidth-1:0] AllOnes      = 25'h1FFFFFF;
  localparam logic [BaseWidth-1:0] StepZeroHigh = 25'h1FC0000;

  localparam base_t DefaultBase [TermCount] = '{RESET_RED_V_BASE, RESET_GREEN_V_BASE,
                                                RESET_GREEN_U_BASE, RESET_BLUE_U_BASE};
  localparam step_t DefaultStep [TermCount] = '{RESET_RED_V_STEP, RESET_GREEN_V_STEP,
                                                RESET_GREEN_U_STEP, RESET_BLUE_U_STEP};

  // Element 0 is the upper left pixel, 3 the lower right.
  typedef logic [3:0][31:0] pixel_quad_t;
  typedef logic [3:0][7:0]  luma_quad_t;

  class block_colour_checker;
    base_t       term_base [TermCount];
    step_t       term_step [TermCount];
    pixel_quad_t expected_quads [$];
    int          mismatch_count;

    function new();
      for (int k = 0; k < TermCount; k++) begin
        term_base[k] = DefaultBase[k];
        term_step[k] = DefaultStep[k];
      end
      mismatch_count = 0;
    endfunction

    function void write_register(logic [IndexWidth-1:0] idx, logic [BaseWidth-1:0] data);
      if (idx > REG_BLUE_U_STEP) begin
        return;
      end
      if (idx[0]) begin
        term_step[idx[2:1]] = data[StepWidth-1:0];
      end else begin
        term_base[idx[2:1]] = $signed(data);
      end
    endfunction

    // The arithmetic shift of a signed sum rounds towards minus infinity.
    function int floor_term(logic [1:0] slot, code_t code);
      longint sum;
      sum = longint'(term_base[slot]) + longint'(term_step[slot]) * longint'(code);
      return int'(sum >>> 16);
    endfunction

    function logic [7:0] saturate(int x);
      if (x < 0) begin
        return 8'd0;
      end
      if (x > 255) begin
        return 8'd255;
      end
      return x[7:0];
    endfunction

    function void note_block(luma_quad_t luma, code_t u, code_t v);
      int          red_term;
      int          green_term;
      int          blue_term;
      int          y;
      pixel_quad_t quad;
      red_term   = floor_term(TERM_RED_V, v);
      green_term = floor_term(TERM_GREEN_V, v) + floor_term(TERM_GREEN_U, u);
      blue_term  = floor_term(TERM_BLUE_U, u);
      for (int k = 0; k < 4; k++) begin
        y = int'(luma[k]);
        quad[k] = {ALPHA_OPAQUE, saturate(y + red_term), saturate(y - green_term),
                   saturate(y + blue_term)};
      end
      expected_quads.push_back(quad);
    endfunction

    function void check_pixels(pixel_quad_t got);
      string       field_names [4] = '{"pixel_top_left", "pixel_top_right",
                                       "pixel_bottom_left", "pixel_bottom_right"};
      pixel_quad_t want;
      if (expected_quads.size() == 0) begin
        $error("result with no item outstanding: %08h %08h %08h %08h",
               got[0], got[1], got[2], got[3]);
        mismatch_count++;
        return;
      end
      want = expected_quads.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[k]) begin
          $error("%s: expected %08h, actual %08h", field_names[k], want[k], got[k]);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [7:0]            luma_top_left = '0;
  logic [7:0]            luma_top_right = '0;
  logic [7:0]            luma_bottom_left = '0;
  logic [7:0]            luma_bottom_right = '0;
  logic [7:0]            chroma_u = '0;
  logic [7:0]            chroma_v = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IndexWidth-1:0] cfg_index = '0;
  logic [BaseWidth-1:0]  cfg_data = '0;
  logic                  done;
  logic [31:0]           pixel_top_left;
  logic [31:0]           pixel_top_right;
  logic [31:0]           pixel_bottom_left;
  logic [31:0]           pixel_bottom_right;

  block_colour_checker colour_check;
  int                  cycle_count = 0;

  yuv420_block_to_argb dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .luma_top_left     (luma_top_left),
    .luma_top_right    (luma_top_right),
    .luma_bottom_left  (luma_bottom_left),
    .luma_bottom_right (luma_bottom_right),
    .chroma_u          (chroma_u),
    .chroma_v          (chroma_v),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .done              (done),
    .pixel_top_left    (pixel_top_left),
    .pixel_top_right   (pixel_top_right),
    .pixel_bottom_left (pixel_bottom_left),
    .pixel_bottom_right(pixel_bottom_right)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      colour_check.check_pixels({pixel_bottom_right, pixel_bottom_left,
                                 pixel_top_right, pixel_top_left});
    end
  end

  // Every task below is entered just after a rising edge and returns just after one.
  // Luma is given as {bottom right, bottom left, top right, top left}.
  task automatic send_block(luma_quad_t luma, code_t u, code_t v);
    start             <= 1'b1;
    luma_top_left     <= luma[0];
    luma_top_right    <= luma[1];
    luma_bottom_left  <= luma[2];
    luma_bottom_right <= luma[3];
    chroma_u          <= u;
    chroma_v          <= v;
    do @(posedge clk); while (busy !== 1'b0);
    colour_check.note_block(luma, u, v);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (colour_check.expected_quads.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Valid is left high so that writes can follow one another without a gap.
  task automatic write_config(logic [IndexWidth-1:0] idx, logic [BaseWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    colour_check.write_register(idx, data);
  endtask

  task automatic load_setting(logic [BaseWidth-1:0] vals [RegCount]);
    for (int i = 0; i < RegCount; i++) begin
      write_config(IndexWidth'(i), vals[i]);
    end
    write_config(IndexWidth'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                 BaseWidth'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Each register gets any value at all or, at even odds, a value near its default, so
  // that the channels are not all pinned at the clamps.
  task automatic load_random_setting();
    logic [BaseWidth-1:0] vals [RegCount];
    logic [StepWidth-1:0] step_low;
    for (int k = 0; k < TermCount; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        vals[2*k] = BaseWidth'($urandom);
      end else begin
        vals[2*k] = BaseWidth'(int'(DefaultBase[k]) + int'($urandom_range(0, 2097152))
                               - 1048576);
      end
      vals[2*k+1] = BaseWidth'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        step_low = StepWidth'(int'(DefaultStep[k]) + int'($urandom_range(0, 32768)) - 16384);
        vals[2*k+1][StepWidth-1:0] = step_low;
      end
    end
    load_setting(vals);
  endtask

  function automatic code_t pick_code();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return code_t'($urandom);
    endcase
  endfunction

  function automatic luma_quad_t pick_luma();
    luma_quad_t luma;
    for (int k = 0; k < 4; k++) begin
      luma[k] = pick_code();
    end
    return luma;
  endfunction

  task automatic send_random_blocks(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      while (burst > 0 && sent < count) begin
        send_block(pick_luma(), pick_code(), pick_code());
        burst--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    colour_check = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default coefficients: clamping at both ends and negative chroma terms.
    send_block({8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 8'd0);
    send_block({8'd255, 8'd255, 8'd255, 8'd255}, 8'd255, 8'd255);
    send_block({8'd255, 8'd0, 8'd255, 8'd0}, 8'd128, 8'd128);
    send_block({8'd0, 8'd255, 8'd0, 8'd255}, 8'd0, 8'd255);
    pause_sender(1);
    send_block({8'd16, 8'd235, 8'd128, 8'd64}, 8'd255, 8'd0);
    send_block({8'd128, 8'd128, 8'd128, 8'd128}, 8'd128, 8'd128);
    send_block({8'd1, 8'd254, 8'd127, 8'd128}, 8'd1, 8'd254);
    send_block({8'd200, 8'd50, 8'd100, 8'd150}, 8'd90, 8'd240);
    send_random_blocks(150);
    drain_pipeline();

    // Smallest bases and zero steps; the step writes carry set upper bits.
    load_setting('{BaseLeast, StepZeroHigh, BaseLeast, StepZeroHigh,
                   BaseLeast, StepZeroHigh, BaseLeast, StepZeroHigh});
    send_block({8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 8'd0);
    send_block({8'd255, 8'd255, 8'd255, 8'd255}, 8'd255, 8'd255);
    send_block({8'd255, 8'd0, 8'd128, 8'd1}, 8'd17, 8'd200);
    send_random_blocks(40);
    drain_pipeline();

    // Largest bases and steps.
    load_setting('{BaseMost, AllOnes, BaseMost, AllOnes,
                   BaseMost, AllOnes, BaseMost, AllOnes});
    send_block({8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 8'd0);
    send_block({8'd255, 8'd255, 8'd255, 8'd255}, 8'd255, 8'd255);
    send_block({8'd0, 8'd255, 8'd0, 8'd255}, 8'd255, 8'd0);
    send_random_blocks(40);
    drain_pipeline();

    // Terms that land exactly on whole units next to ones just below them,
    // so that flooring of small negative sums is visible in the channels.
    load_setting('{25'd0, 25'd65536, AllOnes, StepZeroHigh,
                   25'h1800000, 25'd65536, 25'h1FF8000, 25'd65535});
    send_block({8'd100, 8'd1, 8'd0, 8'd255}, 8'd0, 8'd0);
    send_block({8'd100, 8'd60, 8'd130, 8'd128}, 8'd127, 8'd1);
    send_block({8'd100, 8'd60, 8'd130, 8'd128}, 8'd128, 8'd128);
    send_block({8'd100, 8'd60, 8'd130, 8'd128}, 8'd129, 8'd255);
    send_random_blocks(40);
    drain_pipeline();

    repeat (5) begin
      load_random_setting();
      send_random_blocks(45);
      drain_pipeline();
    end

    load_setting('{DefaultBase[0], DefaultStep[0], DefaultBase[1], DefaultStep[1],
                   DefaultBase[2], DefaultStep[2], DefaultBase[3], DefaultStep[3]});
    send_random_blocks(30);
    drain_pipeline();

    if (colour_check.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/yuv2argb_pkg.sv
hdl/yuv420_block_to_argb.sv
bench/yuv420_block_to_argb_tb.sv
